// ===== src/nvlf_pkg.sv =====
package nvlf_pkg;

  localparam int unsigned COORD_W    = 8;
  localparam int unsigned LABEL_W    = 6;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned STATUS_W   = 2;

  // pixel word layout
  localparam int unsigned PIX_MISSING_BIT = 6;
  localparam int unsigned PIX_FILL_BIT    = 7;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OWN          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FILLED       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_FRAME = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_MASK   = 2'd2;

  localparam logic [DIM_W-1:0]      FRAME_WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0]      FRAME_HEIGHT_RST = 9'd256;
  localparam logic [CFG_DATA_W-1:0] CLASS_MASK_RST   = 64'd0;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // input transaction taken this cycle
    logic own_rd;      // own pixel word is on the RAM read port
    logic scan_issue;  // issue one window read, step offsets
    logic out_load;    // move pending result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_load;    // incoming transaction is a load
    logic req_oof;     // incoming query lies outside the frame
    logic own_fill;    // own pixel carries needs-fill
    logic scan_last;   // current offset is the last of the window
  } sts_t;

endpackage

// ===== src/nvlf_if.sv =====
interface nvlf_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [nvlf_pkg::COORD_W-1:0] row;
  logic [nvlf_pkg::COORD_W-1:0] col;
  logic [nvlf_pkg::LABEL_W-1:0] label;
  logic                        label_missing;
  logic                        needs_fill;

  modport source (output valid, req_type, row, col, label, label_missing, needs_fill,
                  input ready);
  modport sink   (input valid, req_type, row, col, label, label_missing, needs_fill,
                  output ready);
endinterface

interface nvlf_res_if;
  logic                         valid;
  logic                         ready;
  logic [nvlf_pkg::LABEL_W-1:0]  label_out;
  logic                         label_missing_out;
  logic [nvlf_pkg::STATUS_W-1:0] status;

  modport source (output valid, label_out, label_missing_out, status, input ready);
  modport sink   (input valid, label_out, label_missing_out, status, output ready);
endinterface

// ===== src/nvlf_ram.sv =====
module nvlf_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== src/nvlf_ctrl.sv =====
module nvlf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  nvlf_pkg::sts_t     sts_i,
  output nvlf_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_OWN    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.req_load) begin
            state_d = S_IDLE;
          end else if (sts_i.req_oof) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_OWN;
          end
        end
      end
      S_OWN: begin
        cmd_o.own_rd = 1'b1;
        state_d      = sts_i.own_fill ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/nvlf_dp.sv =====
module nvlf_dp #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned WIN_RADIUS = 50
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nvlf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [nvlf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             req_type_i,
  input  logic [nvlf_pkg::COORD_W-1:0]     row_i,
  input  logic [nvlf_pkg::COORD_W-1:0]     col_i,
  input  logic [nvlf_pkg::LABEL_W-1:0]     label_i,
  input  logic                             label_missing_i,
  input  logic                             needs_fill_i,
  input  nvlf_pkg::cmd_t                   cmd_i,
  output nvlf_pkg::sts_t                   sts_o,
  output logic [nvlf_pkg::LABEL_W-1:0]     label_out_o,
  output logic                             label_missing_out_o,
  output logic [nvlf_pkg::STATUS_W-1:0]    status_o
);

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OFS_W  = $clog2(WIN_RADIUS + 1) + 1;
  localparam int unsigned CRD_W  = $clog2(256 + WIN_RADIUS) + 1;
  localparam int unsigned D2_W   = $clog2(2 * WIN_RADIUS * WIN_RADIUS + 1);
  localparam int unsigned DIM_W  = nvlf_pkg::DIM_W;
  localparam int unsigned PIX_W  = nvlf_pkg::PIX_W;
  localparam int unsigned LBL_W  = nvlf_pkg::LABEL_W;

  localparam logic signed [OFS_W-1:0] R_POS = OFS_W'(WIN_RADIUS);
  localparam logic signed [OFS_W-1:0] R_NEG = -R_POS;

  // configuration registers
  logic [DIM_W-1:0]                frame_width_q;
  logic [DIM_W-1:0]                frame_height_q;
  logic [nvlf_pkg::CFG_DATA_W-1:0] class_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= nvlf_pkg::FRAME_WIDTH_RST;
      frame_height_q <= nvlf_pkg::FRAME_HEIGHT_RST;
      class_mask_q   <= nvlf_pkg::CLASS_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nvlf_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[DIM_W-1:0];
        nvlf_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[DIM_W-1:0];
        nvlf_pkg::REG_CLASS_MASK:   class_mask_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame in use, clamped to the memory
  logic [DIM_W-1:0] used_w, used_h;
  assign used_w = (32'(frame_width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : frame_width_q;
  assign used_h = (32'(frame_height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : frame_height_q;

  logic load_in_mem;
  assign load_in_mem = (32'(row_i) < MAX_HEIGHT) && (32'(col_i) < MAX_WIDTH);

  assign sts_o.req_load = (req_type_i == nvlf_pkg::REQ_LOAD);
  assign sts_o.req_oof  = (DIM_W'(row_i) >= used_h) || (DIM_W'(col_i) >= used_w);

  // query position and window offsets
  logic [nvlf_pkg::COORD_W-1:0] row_q, col_q;
  logic signed [OFS_W-1:0]      dy_q, dx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dy_q <= R_NEG;
      dx_q <= R_NEG;
    end else if (cmd_i.accept) begin
      dy_q <= R_NEG;
      dx_q <= R_NEG;
    end else if (cmd_i.scan_issue) begin
      if (dx_q == R_POS) begin
        dx_q <= R_NEG;
        dy_q <= dy_q + OFS_W'(1);
      end else begin
        dx_q <= dx_q + OFS_W'(1);
      end
    end
  end

  assign sts_o.scan_last = (dy_q == R_POS) && (dx_q == R_POS);

  // window read address and squared distance
  logic signed [CRD_W-1:0]   ny, nx;
  logic                      scan_in_frame;
  logic signed [2*OFS_W-1:0] dx_sq, dy_sq;
  logic [D2_W-1:0]           scan_d2;
  logic [ADDR_W-1:0]         scan_addr, own_addr, ram_addr;

  assign ny = $signed(CRD_W'(row_q)) + CRD_W'(dy_q);
  assign nx = $signed(CRD_W'(col_q)) + CRD_W'(dx_q);
  assign scan_in_frame = (ny >= 0) && (ny < $signed(CRD_W'(used_h)))
                      && (nx >= 0) && (nx < $signed(CRD_W'(used_w)));
  assign scan_addr = ADDR_W'(32'(ny[CRD_W-2:0]) * MAX_WIDTH + 32'(nx[CRD_W-2:0]));
  assign own_addr  = ADDR_W'(32'(row_i) * MAX_WIDTH + 32'(col_i));
  assign ram_addr  = cmd_i.accept ? own_addr : scan_addr;

  assign dx_sq   = (2*OFS_W)'(dx_q) * (2*OFS_W)'(dx_q);
  assign dy_sq   = (2*OFS_W)'(dy_q) * (2*OFS_W)'(dy_q);
  assign scan_d2 = D2_W'($unsigned(dx_sq + dy_sq));

  // frame memory
  logic             ram_we;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  assign ram_we    = cmd_i.accept && sts_o.req_load && load_in_mem;
  assign ram_wdata = {needs_fill_i, label_missing_i, label_i};

  nvlf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign sts_o.own_fill = ram_rdata[nvlf_pkg::PIX_FILL_BIT];

  // read-data stage: candidate metadata is registered to line up with the RAM read data
  logic            pipe_q;
  logic            cand_in_q;
  logic [D2_W-1:0] cand_d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= 1'b0;
    end else begin
      pipe_q <= cmd_i.scan_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      cand_in_q <= scan_in_frame;
      cand_d2_q <= scan_d2;
    end
  end

  logic cand_ok, cand_better;
  assign cand_ok = pipe_q && cand_in_q
                && !ram_rdata[nvlf_pkg::PIX_MISSING_BIT]
                && !ram_rdata[nvlf_pkg::PIX_FILL_BIT]
                && class_mask_q[ram_rdata[LBL_W-1:0]];

  // pending result
  logic             found_q, oof_q;
  logic [D2_W-1:0]  best_q;
  logic [PIX_W-1:0] pend_pix_q;

  assign cand_better = !found_q || (cand_d2_q < best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      oof_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      found_q <= 1'b0;
      oof_q   <= sts_o.req_oof;
    end else if (cand_ok && cand_better) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.own_rd) begin
      pend_pix_q <= ram_rdata;
    end else if (cand_ok && cand_better) begin
      pend_pix_q <= ram_rdata;
      best_q     <= cand_d2_q;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (oof_q) begin
        label_out_o         <= '0;
        label_missing_out_o <= 1'b0;
        status_o            <= nvlf_pkg::ST_OUT_OF_FRAME;
      end else begin
        label_missing_out_o <= pend_pix_q[nvlf_pkg::PIX_MISSING_BIT];
        label_out_o         <= pend_pix_q[nvlf_pkg::PIX_MISSING_BIT]
                               ? '0 : pend_pix_q[LBL_W-1:0];
        status_o            <= found_q ? nvlf_pkg::ST_FILLED : nvlf_pkg::ST_OWN;
      end
    end
  end

endmodule

// ===== src/nearest_valid_label_fill.sv =====
// Channel   Role    Payload                                            Handshake
// req       sink    req_type, row, col, label, label_missing,          valid/ready
//                   needs_fill
// res       source  label_out, label_missing_out, status               valid/ready
// cfg       write   cfg_we_i, cfg_idx_i, cfg_data_i                    none
//
// Window scan: a query with needs-fill reads its (2*WIN_RADIUS+1)^2 window
//   through the single frame RAM port, one window pixel per cycle.
// Reset: rst_ni asynchronous, active low; frame RAM contents undefined until loaded.
// Stalls: a finished result waits in the output register; the next transaction
//   is taken meanwhile and only holds at its own result until the register frees.
module nearest_valid_label_fill #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned WIN_RADIUS = 50
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  nvlf_req_if.sink                        req,
  nvlf_res_if.source                      res,
  input  logic                            cfg_we_i,
  input  logic [nvlf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nvlf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  nvlf_pkg::cmd_t cmd;
  nvlf_pkg::sts_t sts;

  // Controller: sequences accept, own-pixel read, window scan, drain and
  // hand-over into the output register.
  nvlf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (res.valid),
    .out_ready_i (res.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: config registers, frame RAM, window counters, nearest-candidate
  // tracking (strict less-than keeps the first hit in row-major order).
  nvlf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WIN_RADIUS (WIN_RADIUS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .req_type_i          (req.req_type),
    .row_i               (req.row),
    .col_i               (req.col),
    .label_i             (req.label),
    .label_missing_i     (req.label_missing),
    .needs_fill_i        (req.needs_fill),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .label_out_o         (res.label_out),
    .label_missing_out_o (res.label_missing_out),
    .status_o            (res.status)
  );

  // a load transaction never leaves the controller busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready && (req.req_type == nvlf_pkg::REQ_LOAD) |=> req.ready)
    else $error("ready dropped after a load transaction");

  // a neighbour fill only ever comes from a labelled pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && (res.status == nvlf_pkg::ST_FILLED) |-> !res.label_missing_out)
    else $error("filled result marked missing");

  // out-of-frame results carry a zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && (res.status == nvlf_pkg::ST_OUT_OF_FRAME)
      |-> (res.label_out == '0) && !res.label_missing_out)
    else $error("out-of-frame result with non-zero payload");

  // a missing result has a zero class value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.label_missing_out |-> (res.label_out == '0))
    else $error("missing result with non-zero class");

endmodule

// ===== sim/tb_nearest_valid_label_fill.sv =====
module tb_nearest_valid_label_fill;

  localparam int COORD_W    = nvlf_pkg::COORD_W;
  localparam int LABEL_W    = nvlf_pkg::LABEL_W;
  localparam int PIX_W      = nvlf_pkg::PIX_W;
  localparam int DIM_W      = nvlf_pkg::DIM_W;
  localparam int CFG_DATA_W = nvlf_pkg::CFG_DATA_W;
  localparam int CFG_IDX_W  = nvlf_pkg::CFG_IDX_W;
  localparam int STATUS_W   = nvlf_pkg::STATUS_W;

  localparam int MEM_SIDE   = 256;   // frame RAM is MEM_SIDE x MEM_SIDE
  localparam int PRE_SIDE   = 4;     // preloaded patch: rows and columns 0..PRE_SIDE-1
  localparam int RADIUS     = 50;
  localparam int HOLD_CYC   = 400;   // long receiver hold-off
  localparam int PHASE_ITEMS = 10;
  localparam int NUM_PHASES  = 5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, ignored

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [LABEL_W-1:0] label;
    logic               label_missing;
    logic               needs_fill;
  } pix_req_t;

  typedef struct packed {
    logic [LABEL_W-1:0]  label;
    logic                missing;
    logic [STATUS_W-1:0] status;
  } fill_res_t;

  typedef enum {ROW_REQ, ROW_CFG} row_kind_e;

  // one line of the directed table: either a transaction or a register write
  typedef struct {
    row_kind_e            kind;
    pix_req_t             rq;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    bit                   typed;   // expected result written into the table
    fill_res_t            res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  nvlf_req_if req_ch ();
  nvlf_res_if res_ch ();

  nearest_valid_label_fill #(
    .MAX_WIDTH  (MEM_SIDE),
    .MAX_HEIGHT (MEM_SIDE),
    .WIN_RADIUS (RADIUS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shadow of the frame RAM and of the three registers
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]      shadow_frame [MEM_SIDE*MEM_SIDE];
  logic [DIM_W-1:0]      shadow_width;
  logic [DIM_W-1:0]      shadow_height;
  logic [CFG_DATA_W-1:0] shadow_classes;

  fill_res_t pending_labels [$];   // results still owed by the block, oldest first
  int unsigned mismatches;

  // sender burst/gap bookkeeping
  bit idle_on;
  int unsigned burst_left;
  // set by the stimulus, cleared by the receiver when it starts the hold-off
  bit hold_go;

  // ---------------------------------------------------------------------------
  // Expected result of a query at (r, c) given the shadow state.
  // Window walk is row offset outer, column offset inner, both rising; a strict
  // '<' keeps the first pixel among equal squared distances.
  // ---------------------------------------------------------------------------
  function automatic fill_res_t predict_label(input logic [COORD_W-1:0] r,
                                              input logic [COORD_W-1:0] c);
    fill_res_t o;
    int w, h, ny, nx, d2, best;
    logic [PIX_W-1:0] own, pick, p;
    bit found;
    w = (int'(shadow_width)  > MEM_SIDE) ? MEM_SIDE : int'(shadow_width);
    h = (int'(shadow_height) > MEM_SIDE) ? MEM_SIDE : int'(shadow_height);
    o = '0;
    if (int'(r) >= h || int'(c) >= w) begin
      o.status = nvlf_pkg::ST_OUT_OF_FRAME;
      return o;
    end
    own   = shadow_frame[{r, c}];
    pick  = own;
    found = 1'b0;
    best  = 0;
    o.status = nvlf_pkg::ST_OWN;
    if (own[nvlf_pkg::PIX_FILL_BIT]) begin
      for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
        ny = int'(r) + dy;
        if (ny < 0 || ny >= h) continue;
        for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
          nx = int'(c) + dx;
          if (nx < 0 || nx >= w) continue;
          p = shadow_frame[ny*MEM_SIDE + nx];
          // usable neighbour: labelled, settled, and its class enabled
          if (p[nvlf_pkg::PIX_MISSING_BIT] || p[nvlf_pkg::PIX_FILL_BIT]
              || !shadow_classes[p[LABEL_W-1:0]])
            continue;
          d2 = dx*dx + dy*dy;
          if (!found || d2 < best) begin
            found = 1'b1;
            best  = d2;
            pick  = p;
          end
        end
      end
      if (found) o.status = nvlf_pkg::ST_FILLED;
    end
    // a missing value always reads back as class 0
    if (pick[nvlf_pkg::PIX_MISSING_BIT]) begin
      o.label   = '0;
      o.missing = 1'b1;
    end else begin
      o.label   = pick[LABEL_W-1:0];
      o.missing = 1'b0;
    end
    return o;
  endfunction

  function automatic fill_res_t mk_res(input logic [LABEL_W-1:0] lab, input logic miss,
                                       input logic [STATUS_W-1:0] st);
    fill_res_t o;
    o.label   = lab;
    o.missing = miss;
    o.status  = st;
    return o;
  endfunction

  function automatic dir_row_t load_row(input int r, input int c, input int lab,
                                        input bit miss, input bit fill);
    dir_row_t d;
    d.kind  = ROW_REQ;
    d.rq    = '{req_type: nvlf_pkg::REQ_LOAD, row: r[7:0], col: c[7:0], label: lab[5:0],
                label_missing: miss, needs_fill: fill};
    d.idx   = '0;
    d.data  = '0;
    d.typed = 1'b0;
    d.res   = '0;
    return d;
  endfunction

  function automatic dir_row_t query_row(input int r, input int c, input bit typed,
                                         input fill_res_t res);
    dir_row_t d;
    // payload fields beyond the address are don't-care on a query; drive ones
    d.kind  = ROW_REQ;
    d.rq    = '{req_type: nvlf_pkg::REQ_QUERY, row: r[7:0], col: c[7:0], label: '1,
                label_missing: 1'b1, needs_fill: 1'b1};
    d.idx   = '0;
    d.data  = '0;
    d.typed = typed;
    d.res   = res;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t d;
    d.kind  = ROW_CFG;
    d.rq    = '0;
    d.idx   = idx;
    d.data  = data;
    d.typed = 1'b0;
    d.res   = '0;
    return d;
  endfunction

  // random transaction, mostly clustered round (cr, cc) so that loads shape
  // the neighbourhood of later queries; the rest anywhere in the address space
  function automatic pix_req_t rand_req(input int cr, input int cc, input int span,
                                        input logic [LABEL_W-1:0] hot);
    pix_req_t it;
    int r, c;
    it.req_type = ($urandom_range(0, 99) < 55) ? nvlf_pkg::REQ_LOAD : nvlf_pkg::REQ_QUERY;
    if ($urandom_range(0, 9) < 7) begin
      r = cr - span + int'($urandom_range(0, 2*span));
      c = cc - span + int'($urandom_range(0, 2*span));
      r = (r < 0) ? 0 : (r > MEM_SIDE-1) ? MEM_SIDE-1 : r;
      c = (c < 0) ? 0 : (c > MEM_SIDE-1) ? MEM_SIDE-1 : c;
    end else begin
      r = $urandom_range(0, MEM_SIDE-1);
      c = $urandom_range(0, MEM_SIDE-1);
    end
    it.row           = r[7:0];
    it.col           = c[7:0];
    it.label         = $urandom_range(0, 1) ? hot : LABEL_W'($urandom);
    it.label_missing = ($urandom_range(0, 5) == 0);
    it.needs_fill    = ($urandom_range(0, 2) == 0);
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_classes(input logic [LABEL_W-1:0] hot);
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << hot;
      3:       return {$urandom, $urandom};
      default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  // frame dimension register value: zero, one, or up to the preloaded patch
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd1;
      2, 3:    return DIM_W'(PRE_SIDE);
      default: return DIM_W'($urandom_range(1, PRE_SIDE));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving: everything changes on the falling edge
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    case (idx)
      nvlf_pkg::REG_FRAME_WIDTH:  shadow_width   = data[DIM_W-1:0];
      nvlf_pkg::REG_FRAME_HEIGHT: shadow_height  = data[DIM_W-1:0];
      nvlf_pkg::REG_CLASS_MASK:   shadow_classes = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offer one transaction and hold it until taken. Valid is left high on
  // return so that a back-to-back transaction does not toggle it.
  task automatic send_req(input pix_req_t it, input bit typed, input fill_res_t res);
    req_ch.valid         = 1'b1;
    req_ch.req_type      = it.req_type;
    req_ch.row           = it.row;
    req_ch.col           = it.col;
    req_ch.label         = it.label;
    req_ch.label_missing = it.label_missing;
    req_ch.needs_fill    = it.needs_fill;
    do @(posedge clk_i); while (!req_ch.ready);
    // taken at this edge: update the shadow in acceptance order
    if (it.req_type == nvlf_pkg::REQ_LOAD)
      shadow_frame[{it.row, it.col}] = {it.needs_fill, it.label_missing, it.label};
    else
      pending_labels.push_back(typed ? res : predict_label(it.row, it.col));
    @(negedge clk_i);
  endtask

  // sender in bursts of random length, with random gaps between them
  task automatic offer(input pix_req_t it, input bit typed, input fill_res_t res);
    int unsigned gap;
    if (idle_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    send_req(it, typed, res);
  endtask

  // block idle: no transaction offered, all results in, trailing load retired
  task automatic settle();
    req_ch.valid = 1'b0;
    while (pending_labels.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #32_000_000;
    $display("tb_nearest_valid_label_fill NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern that changes at random intervals, plus one long
  // hold-off on request so the output register fills and the input backs up.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode, left, tick;
    res_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go      = 1'b0;
        res_ch.ready = 1'b0;
        repeat (HOLD_CYC - 1) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 80);
        end
        left--;
        tick++;
        case (mode)
          0:       res_ch.ready = 1'b1;
          1:       res_ch.ready = $urandom_range(0, 1);
          2:       res_ch.ready = ($urandom_range(0, 3) == 0);
          default: res_ch.ready = (tick % 5) >= 2;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every result transaction against the oldest outstanding one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : res_check
    fill_res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_labels.size() == 0) begin
        $display("%0t: unexpected result: label_out %0d missing %0d status %0d",
                 $time, res_ch.label_out, res_ch.label_missing_out, res_ch.status);
        mismatches++;
      end else begin
        want = pending_labels.pop_front();
        if (res_ch.label_out !== want.label) begin
          $display("%0t: label_out expected %0d got %0d", $time, want.label,
                   res_ch.label_out);
          mismatches++;
        end
        if (res_ch.label_missing_out !== want.missing) begin
          $display("%0t: label_missing_out expected %0d got %0d", $time, want.missing,
                   res_ch.label_missing_out);
          mismatches++;
        end
        if (res_ch.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, res_ch.status);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t dir_tab [$];
    pix_req_t it;
    int w, h, cr, cc, span;
    logic [LABEL_W-1:0] hot;
    logic [DIM_W-1:0] dim;
    logic [CFG_DATA_W-1:0] word;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = nvlf_pkg::REQ_LOAD;
    req_ch.row           = '0;
    req_ch.col           = '0;
    req_ch.label         = '0;
    req_ch.label_missing = 1'b0;
    req_ch.needs_fill    = 1'b0;
    shadow_width         = nvlf_pkg::FRAME_WIDTH_RST;
    shadow_height        = nvlf_pkg::FRAME_HEIGHT_RST;
    shadow_classes       = nvlf_pkg::CLASS_MASK_RST;
    mismatches           = 0;
    idle_on              = 1'b0;
    burst_left           = 0;
    hold_go              = 1'b0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Load the small patch at the origin first. Every frame used with a
    // needs-fill query lies inside it, so no window scan touches an unwritten
    // word; full-frame queries only ever read pixels loaded just before.
    for (int i = 0; i < PRE_SIDE*PRE_SIDE; i++) begin
      it.req_type      = nvlf_pkg::REQ_LOAD;
      it.row           = COORD_W'(i / PRE_SIDE);
      it.col           = COORD_W'(i % PRE_SIDE);
      it.label         = LABEL_W'($urandom);
      it.label_missing = ($urandom_range(0, 7) == 0);
      it.needs_fill    = $urandom_range(0, 1);
      send_req(it, 1'b0, '0);
    end
    settle();

    // Directed table. Rows with a typed result are readable by eye; the rest
    // go through the predictor.
    // reset settings: full frame, no class enabled, own values only
    dir_tab.push_back(load_row(0, 0, 63, 1'b0, 1'b0));
    dir_tab.push_back(query_row(0, 0, 1'b1, mk_res(6'd63, 1'b0, nvlf_pkg::ST_OWN)));
    dir_tab.push_back(load_row(255, 255, 0, 1'b1, 1'b0));
    dir_tab.push_back(query_row(255, 255, 1'b1, mk_res(6'd0, 1'b1, nvlf_pkg::ST_OWN)));
    dir_tab.push_back(load_row(128, 77, 0, 1'b0, 1'b0));
    dir_tab.push_back(query_row(128, 77, 1'b1, mk_res(6'd0, 1'b0, nvlf_pkg::ST_OWN)));
    // shrink to the patch; still no class enabled -> nothing can fill
    dir_tab.push_back(cfg_row(nvlf_pkg::REG_FRAME_WIDTH, 64'd4));
    dir_tab.push_back(cfg_row(nvlf_pkg::REG_FRAME_HEIGHT, 64'd4));
    dir_tab.push_back(load_row(0, 1, 5, 1'b0, 1'b1));
    dir_tab.push_back(query_row(0, 1, 1'b1, mk_res(6'd5, 1'b0, nvlf_pkg::ST_OWN)));
    dir_tab.push_back(load_row(0, 2, 7, 1'b1, 1'b1));
    dir_tab.push_back(query_row(0, 2, 1'b1, mk_res(6'd0, 1'b1, nvlf_pkg::ST_OWN)));
    // every class enabled: fills from the nearest settled neighbour
    dir_tab.push_back(cfg_row(nvlf_pkg::REG_CLASS_MASK, '1));
    dir_tab.push_back(query_row(0, 1, 1'b0, '0));
    dir_tab.push_back(query_row(0, 2, 1'b0, '0));
    dir_tab.push_back(load_row(3, 2, 42, 1'b0, 1'b0));
    dir_tab.push_back(load_row(3, 3, 9, 1'b0, 1'b1));
    dir_tab.push_back(query_row(3, 3, 1'b0, '0));
    // top class only, then bottom class only
    dir_tab.push_back(cfg_row(nvlf_pkg::REG_CLASS_MASK, 64'h8000_0000_0000_0000));
    dir_tab.push_back(query_row(0, 1, 1'b0, '0));
    dir_tab.push_back(cfg_row(nvlf_pkg::REG_CLASS_MASK, 64'h1));
    dir_tab.push_back(query_row(0, 2, 1'b0, '0));
    // zero width: everything out of frame
    dir_tab.push_back(cfg_row(nvlf_pkg::REG_FRAME_WIDTH, 64'h0));
    dir_tab.push_back(query_row(0, 0, 1'b1,
                                mk_res(6'd0, 1'b0, nvlf_pkg::ST_OUT_OF_FRAME)));
    // oversize width clamps to the RAM; single row; junk above the field
    dir_tab.push_back(cfg_row(nvlf_pkg::REG_FRAME_WIDTH, 64'hA5A5_5A5A_F00D_01FF));
    dir_tab.push_back(cfg_row(nvlf_pkg::REG_FRAME_HEIGHT, 64'h1));
    dir_tab.push_back(query_row(1, 0, 1'b1,
                                mk_res(6'd0, 1'b0, nvlf_pkg::ST_OUT_OF_FRAME)));
    dir_tab.push_back(load_row(0, 255, 33, 1'b0, 1'b0));
    dir_tab.push_back(query_row(0, 255, 1'b0, '0));
    // 1x1 frame; unmapped index must leave the registers alone
    dir_tab.push_back(cfg_row(nvlf_pkg::REG_FRAME_WIDTH, 64'h1));
    dir_tab.push_back(cfg_row(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_tab.push_back(query_row(0, 0, 1'b0, '0));
    dir_tab.push_back(query_row(0, 1, 1'b1,
                                mk_res(6'd0, 1'b0, nvlf_pkg::ST_OUT_OF_FRAME)));
    dir_tab.push_back(query_row(255, 0, 1'b1,
                                mk_res(6'd0, 1'b0, nvlf_pkg::ST_OUT_OF_FRAME)));

    idle_on = 1'b1;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        offer(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Back-pressure: full frame, fast non-fill queries offered while the
    // receiver sits on its hands, so the output register fills and req stalls.
    settle();
    write_reg(nvlf_pkg::REG_FRAME_WIDTH, 64'd256);
    write_reg(nvlf_pkg::REG_FRAME_HEIGHT, 64'd256);
    hold_go = 1'b1;
    for (int i = 0; i < 6; i++) begin
      it.req_type      = nvlf_pkg::REQ_LOAD;
      it.row           = COORD_W'($urandom);
      it.col           = COORD_W'(i * 41);
      it.label         = LABEL_W'($urandom);
      it.label_missing = $urandom_range(0, 1);
      it.needs_fill    = 1'b0;
      send_req(it, 1'b0, '0);
      dir_tab[i].rq = it;   // table reused as scratch for the query addresses
    end
    for (int i = 0; i < 6; i++) begin
      it          = dir_tab[i].rq;
      it.req_type = nvlf_pkg::REQ_QUERY;
      send_req(it, 1'b0, '0);
    end

    // Random phases, each under its own register setting. The first pins the
    // whole patch with every class enabled; later ones roam its sizes, extremes included.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      hot = LABEL_W'($urandom);
      dim = (ph == 0) ? DIM_W'(PRE_SIDE) : pick_dim();
      word = {$urandom, $urandom};
      write_reg(nvlf_pkg::REG_FRAME_WIDTH, {word[CFG_DATA_W-1:DIM_W], dim});
      w = (int'(dim) > MEM_SIDE) ? MEM_SIDE : int'(dim);
      dim = (ph == 0) ? DIM_W'(PRE_SIDE) : pick_dim();
      word = {$urandom, $urandom};
      write_reg(nvlf_pkg::REG_FRAME_HEIGHT, {word[CFG_DATA_W-1:DIM_W], dim});
      h = (int'(dim) > MEM_SIDE) ? MEM_SIDE : int'(dim);
      write_reg(nvlf_pkg::REG_CLASS_MASK, (ph == 0) ? '1 : pick_classes(hot));
      // cluster inside the frame where there is one
      cr   = (h > 0) ? $urandom_range(0, h - 1) : $urandom_range(0, MEM_SIDE - 1);
      cc   = (w > 0) ? $urandom_range(0, w - 1) : $urandom_range(0, MEM_SIDE - 1);
      span = $urandom_range(1, 4);
      for (int n = 0; n < PHASE_ITEMS; n++)
        offer(rand_req(cr, cc, span, hot), 1'b0, '0);
    end

    req_ch.valid = 1'b0;
    while (pending_labels.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0)
      $display("tb_nearest_valid_label_fill OK");
    else
      $display("tb_nearest_valid_label_fill NOT OK");
    $finish;
  end

endmodule
